### rtl/aesp_pkg.sv
// ---------------------------------------------------------------------------
// aesp_pkg: shared types and constants of the escape sequence parser
// Command codes, register indexes, byte codes, mode numbers, the largest
// parameter value and the parameter store control bundle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aesp_pkg;

  // result command codes
  localparam logic [4:0] CMD_CHAR     = 5'd0;
  localparam logic [4:0] CMD_UP       = 5'd1;
  localparam logic [4:0] CMD_DOWN     = 5'd2;
  localparam logic [4:0] CMD_RIGHT    = 5'd3;
  localparam logic [4:0] CMD_LEFT     = 5'd4;
  localparam logic [4:0] CMD_SET_CUR  = 5'd5;
  localparam logic [4:0] CMD_SET_ROW  = 5'd6;
  localparam logic [4:0] CMD_SET_COL  = 5'd7;
  localparam logic [4:0] CMD_ERASE_SC = 5'd8;
  localparam logic [4:0] CMD_ERASE_LN = 5'd9;
  localparam logic [4:0] CMD_SCR_DOWN = 5'd10;
  localparam logic [4:0] CMD_SCR_UP   = 5'd11;
  localparam logic [4:0] CMD_INS_CH   = 5'd12;
  localparam logic [4:0] CMD_DEL_CH   = 5'd13;
  localparam logic [4:0] CMD_REGION   = 5'd14;
  localparam logic [4:0] CMD_SAVE     = 5'd15;
  localparam logic [4:0] CMD_RESTORE  = 5'd16;
  localparam logic [4:0] CMD_SWITCH   = 5'd17;
  localparam logic [4:0] CMD_RESET    = 5'd18;
  localparam logic [4:0] CMD_ATTR     = 5'd19;
  localparam logic [4:0] CMD_MODES    = 5'd20;

  // configuration register indexes
  localparam logic [1:0] REG_DEF_FG = 2'd0;
  localparam logic [1:0] REG_DEF_BG = 2'd1;
  localparam logic [1:0] REG_ROWS   = 2'd2;

  // byte codes
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_INT_LO = 8'h20;
  localparam logic [7:0] CH_INT_HI = 8'h2F;
  localparam logic [7:0] CH_FIN_LO = 8'h40;
  localparam logic [7:0] CH_FIN_HI = 8'h7E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_L  = 8'h6C;
  localparam logic [7:0] CH_LC_M  = 8'h6D;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_U  = 8'h75;

  // mode numbers
  localparam logic [15:0] MODE_INSERT = 16'd4;
  localparam logic [15:0] MODE_CURSOR = 16'd25;
  localparam logic [15:0] MODE_ALT    = 16'd1049;
  localparam logic [15:0] MODE_PASTE  = 16'd2004;

  // largest parameter value
  localparam logic [19:0] PARAM_SAT = 20'd65535;

  // parameter store control
  typedef struct packed {
    logic       clr;
    logic       acc;
    logic [3:0] digit;
  } prm_ctrl_t;

endpackage
`default_nettype wire

### rtl/aesp_params.sv
// ---------------------------------------------------------------------------
// aesp_params: CSI parameter store
// Holds the decimal parameters, clears them on sequence entry and folds one
// digit a beat into the addressed entry with saturation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aesp_params #(
  parameter int MAX_PARAMS = 16,
  parameter int IW = 4
) (
  input  wire                    clk,
  input  aesp_pkg::prm_ctrl_t    ctrl,
  input  wire  [IW-1:0]          idx,
  output logic [15:0]            rd_data,
  output logic [15:0]            p_first,
  output logic [15:0]            p_second
);
  import aesp_pkg::*;

  logic [15:0] mem [MAX_PARAMS];
  logic [19:0] acc_sum;

  // value times ten plus digit
  always_comb begin
    rd_data = mem[idx];
    acc_sum = {1'b0, rd_data, 3'b000} + {3'b000, rd_data, 1'b0} + {16'd0, ctrl.digit};
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      for (int j = 0; j < MAX_PARAMS; j++) mem[j] <= '0;
    end else if (ctrl.acc) begin
      mem[idx] <= (acc_sum > PARAM_SAT) ? 16'hFFFF : acc_sum[15:0];
    end
  end

  assign p_first = mem[0];

  generate
    if (MAX_PARAMS > 1) begin : g_two
      assign p_second = mem[1];
    end else begin : g_one
      assign p_second = '0;
    end
  endgenerate

endmodule
`default_nettype wire

### rtl/ansi_escape_sequence_parser.sv
// ---------------------------------------------------------------------------
// ansi_escape_sequence_parser: terminal escape sequence decoder
// Turns a terminal byte stream into screen commands with SGR and mode state.
// ---------------------------------------------------------------------------
// Usage:
//   s_* takes one stream byte a beat. m_* gives at most one command beat per
//   byte; bytes inside sequences, OSC and DCS strings give none.
//   cfg_* writes the default colors and the screen height; write only while
//   the block is idle.
// Timing:
//   A byte is taken when the sequencer is idle and decoded in the next cycle;
//   its result, if it gives one, is loaded into the output register from the
//   emit state once that register is free. An SGR final byte walks the
//   stored parameters one per cycle on the parameter store read port, but a
//   38 or 48 whose next parameter is not 5 reads that parameter twice.
//   A new byte is taken while the previous result still waits in the output
//   register; a stalled receiver holds the sequencer before the next load.
// Reset:
//   rst (synchronous) returns to ground state, restores default colors
//   (7 and 0), 24 rows, clears attributes and mode flags and the output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ansi_escape_sequence_parser #(
  parameter int MAX_PARAMS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] byte_in
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [63:0] m_tdata,   // [4:0] command, [20:5] arg_first,
                                 // [36:21] arg_second, [44:37] foreground,
                                 // [52:45] background, [58:53] attributes,
                                 // [59] cursor_shown, [60] paste_bracketed,
                                 // [61] insert_on, [63:62] zero
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);
  import aesp_pkg::*;

  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW = $clog2(MAX_PARAMS + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SGR, S_EMIT} seq_t;
  typedef enum logic [2:0] {P_GROUND, P_ESC, P_CSI, P_OSC, P_DCS, P_STR} pst_t;
  typedef enum logic [1:0] {PH_NORM, PH_CHK, PH_COL} phase_t;

  seq_t        st;
  pst_t        pst;
  phase_t      phase;
  logic [7:0]  b;
  logic [CW-1:0] cnt;
  logic [CW-1:0] pidx;
  logic        priv;
  logic        tgt_bg;
  logic [7:0]  def_fg, def_bg, rows;
  logic [7:0]  fg, bg;
  logic [5:0]  attr;
  logic [2:0]  mode;
  logic [4:0]  cmd;
  logic [15:0] a1, a2;

  prm_ctrl_t   pctl;
  logic [IW-1:0] idx;
  logic [15:0] rd, m0, m1;
  logic [CW-1:0] cnt_m1;
  logic [IW-1:0] k;
  logic [15:0] p1, p2, n1, n2, bot;
  logic        is_digit;
  logic        two_more;

  aesp_params #(.MAX_PARAMS(MAX_PARAMS), .IW(IW)) u_params (
    .clk      (clk),
    .ctrl     (pctl),
    .idx      (idx),
    .rd_data  (rd),
    .p_first  (m0),
    .p_second (m1)
  );

  // decode helpers
  always_comb begin
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    cnt_m1   = cnt - CW'(1);
    k        = (cnt == '0) ? '0 : cnt_m1[IW-1:0];
    idx      = (st == S_SGR) ? pidx[IW-1:0] : k;
    pctl.clr   = (st == S_EXEC) && (pst == P_ESC) && (b == CH_LBRK);
    pctl.acc   = (st == S_EXEC) && (pst == P_CSI) && is_digit;
    pctl.digit = b[3:0];
    p1  = (cnt > CW'(0)) ? m0 : '0;
    p2  = (cnt > CW'(1)) ? m1 : '0;
    n1  = (p1 == '0) ? 16'd1 : p1;
    n2  = (p2 == '0) ? 16'd1 : p2;
    bot = (p2 != '0) ? p2 : {8'd0, rows};
    two_more = ({1'b0, pidx} + (CW+1)'(2)) < {1'b0, cnt};
  end

  assign s_tready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= S_IDLE;
      pst      <= P_GROUND;
      phase    <= PH_NORM;
      cnt      <= '0;
      pidx     <= '0;
      priv     <= 1'b0;
      tgt_bg   <= 1'b0;
      def_fg   <= 8'd7;
      def_bg   <= 8'd0;
      rows     <= 8'd24;
      fg       <= 8'd7;
      bg       <= 8'd0;
      attr     <= '0;
      mode     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DEF_FG: def_fg <= cfg_data;
          REG_DEF_BG: def_bg <= cfg_data;
          REG_ROWS:   rows   <= cfg_data;
          default: ;
        endcase
      end

      // output beat taken; a load in S_EMIT keeps it valid
      if (m_tvalid && m_tready && (st != S_EMIT)) m_tvalid <= 1'b0;

      unique case (st)
        S_IDLE: begin
          if (s_tvalid) begin
            b  <= s_tdata;
            st <= S_EXEC;
          end
        end

        S_EXEC: begin
          st <= S_IDLE;
          a1 <= '0;
          a2 <= '0;
          unique case (pst)
            P_ESC: begin
              pst <= P_GROUND;
              priority if (b == CH_LBRK) begin
                pst  <= P_CSI;
                cnt  <= '0;
                priv <= 1'b0;
              end else if (b == CH_RBRK) begin
                pst <= P_OSC;
              end else if (b == CH_P) begin
                pst <= P_DCS;
              end else if (b == CH_LC_C) begin
                fg   <= def_fg;
                bg   <= def_bg;
                attr <= '0;
                mode <= '0;
                cmd  <= CMD_RESET;
                st   <= S_EMIT;
              end else if (b == CH_7) begin
                cmd <= CMD_SAVE;
                st  <= S_EMIT;
              end else if (b == CH_8) begin
                cmd <= CMD_RESTORE;
                st  <= S_EMIT;
              end else if (b == CH_M) begin
                cmd <= CMD_SCR_DOWN;
                a1  <= 16'd1;
                st  <= S_EMIT;
              end else if (b == CH_D) begin
                cmd <= CMD_SCR_UP;
                a1  <= 16'd1;
                st  <= S_EMIT;
              end else begin
              end
            end

            P_CSI: begin
              priority if (b == CH_QUEST) begin
                priv <= 1'b1;
              end else if (is_digit) begin
                if (cnt == '0) cnt <= CW'(1);
              end else if (b == CH_SEMI) begin
                if (cnt == '0) cnt <= (MAX_PARAMS >= 2) ? CW'(2) : CW'(1);
                else if (cnt < CW'(MAX_PARAMS)) cnt <= cnt + CW'(1);
              end else if (b >= CH_INT_LO && b <= CH_INT_HI) begin
              end else if (b >= CH_FIN_LO && b <= CH_FIN_HI) begin
                pst <= P_GROUND;
                st  <= S_EMIT;
                priority case (b)
                  CH_A:     begin cmd <= CMD_UP;       a1 <= n1; end
                  CH_B:     begin cmd <= CMD_DOWN;     a1 <= n1; end
                  CH_C:     begin cmd <= CMD_RIGHT;    a1 <= n1; end
                  CH_D:     begin cmd <= CMD_LEFT;     a1 <= n1; end
                  CH_H, CH_LC_F: begin
                    cmd <= CMD_SET_CUR;
                    a1  <= n1 - 16'd1;
                    a2  <= n2 - 16'd1;
                  end
                  CH_J:     begin cmd <= CMD_ERASE_SC; a1 <= p1; end
                  CH_K:     begin cmd <= CMD_ERASE_LN; a1 <= p1; end
                  CH_L:     begin cmd <= CMD_SCR_DOWN; a1 <= n1; end
                  CH_M:     begin cmd <= CMD_SCR_UP;   a1 <= n1; end
                  CH_AT:    begin cmd <= CMD_INS_CH;   a1 <= n1; end
                  CH_P:     begin cmd <= CMD_DEL_CH;   a1 <= n1; end
                  CH_LC_D:  begin cmd <= CMD_SET_ROW;  a1 <= n1 - 16'd1; end
                  CH_G, CH_BTICK: begin cmd <= CMD_SET_COL; a1 <= n1 - 16'd1; end
                  CH_LC_M: begin
                    cmd <= CMD_ATTR;
                    if (cnt == '0) begin
                      fg   <= def_fg;
                      bg   <= def_bg;
                      attr <= '0;
                    end else begin
                      pidx  <= '0;
                      phase <= PH_NORM;
                      st    <= S_SGR;
                    end
                  end
                  CH_LC_R: begin
                    cmd <= CMD_REGION;
                    a1  <= n1 - 16'd1;
                    a2  <= (bot != '0) ? bot - 16'd1 : '0;
                  end
                  CH_LC_S:  cmd <= CMD_SAVE;
                  CH_LC_U:  cmd <= CMD_RESTORE;
                  CH_LC_H, CH_LC_L: begin
                    cmd <= CMD_MODES;
                    priority if (priv && p1 == MODE_ALT) begin
                      cmd <= CMD_SWITCH;
                      a1  <= {15'd0, (b == CH_LC_H)};
                    end else if (priv && p1 == MODE_CURSOR) begin
                      mode[0] <= (b == CH_LC_H);
                    end else if (priv && p1 == MODE_PASTE) begin
                      mode[1] <= (b == CH_LC_H);
                    end else if (!priv && p1 == MODE_INSERT) begin
                      mode[2] <= (b == CH_LC_H);
                    end else begin
                      st <= S_IDLE;
                    end
                  end
                  default: st <= S_IDLE;
                endcase
              end else begin
                pst <= P_GROUND;
              end
            end

            P_OSC: begin
              if (b == CH_BEL) pst <= P_GROUND;
              else if (b == CH_ESC) pst <= P_STR;
            end

            P_DCS: begin
              if (b == CH_ESC) pst <= P_STR;
            end

            P_STR: pst <= P_GROUND;

            default: begin
              if (b == CH_ESC) begin
                pst <= P_ESC;
              end else begin
                pst <= P_GROUND;
                cmd <= CMD_CHAR;
                a1  <= {8'd0, b};
                st  <= S_EMIT;
              end
            end
          endcase
        end

        // one stored parameter a cycle; a 38 or 48 not followed by 5 rereads the next
        S_SGR: begin
          unique case (phase)
            PH_CHK: begin
              // not ;5;n: the parameter after 38 or 48 is walked as usual
              if (rd == 16'd5) begin
                pidx  <= pidx + CW'(1);
                phase <= PH_COL;
              end else begin
                phase <= PH_NORM;
              end
            end
            PH_COL: begin
              if (tgt_bg) bg <= rd[7:0];
              else fg <= rd[7:0];
              pidx  <= pidx + CW'(1);
              phase <= PH_NORM;
            end
            default: begin
              if (pidx >= cnt) begin
                st <= S_EMIT;
              end else begin
                pidx <= pidx + CW'(1);
                priority if (rd == 16'd0) begin
                  fg <= def_fg; bg <= def_bg; attr <= '0;
                end else if (rd == 16'd1)  attr[0] <= 1'b1;
                else if (rd == 16'd3)  attr[2] <= 1'b1;
                else if (rd == 16'd4)  attr[1] <= 1'b1;
                else if (rd == 16'd5)  attr[3] <= 1'b1;
                else if (rd == 16'd7)  attr[4] <= 1'b1;
                else if (rd == 16'd9)  attr[5] <= 1'b1;
                else if (rd == 16'd22) attr[0] <= 1'b0;
                else if (rd == 16'd23) attr[2] <= 1'b0;
                else if (rd == 16'd24) attr[1] <= 1'b0;
                else if (rd == 16'd25) attr[3] <= 1'b0;
                else if (rd == 16'd27) attr[4] <= 1'b0;
                else if (rd == 16'd29) attr[5] <= 1'b0;
                else if (rd >= 16'd30 && rd <= 16'd37) fg <= rd[7:0] - 8'd30;
                else if ((rd == 16'd38 || rd == 16'd48) && two_more) begin
                  tgt_bg <= (rd == 16'd48);
                  phase  <= PH_CHK;
                end
                else if (rd == 16'd39) fg <= def_fg;
                else if (rd >= 16'd40 && rd <= 16'd47) bg <= rd[7:0] - 8'd40;
                else if (rd == 16'd49) bg <= def_bg;
                else if (rd >= 16'd90 && rd <= 16'd97) fg <= rd[7:0] - 8'd82;
                else if (rd >= 16'd100 && rd <= 16'd107) bg <= rd[7:0] - 8'd92;
                else begin
                end
              end
            end
          endcase
        end

        // load the output register once it is free
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {2'b00, mode[2], mode[1], mode[0], attr, bg, fg, a2, a1, cmd};
            st       <= S_IDLE;
          end
        end

        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
